// ===== rtl/core/rsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsp_pkg
// Shared types and codes for the run-length product merge block.
// ----------------------------------------------------------------------------
package rsp_pkg;

    typedef logic [1:0] t_req;
    typedef logic [1:0] t_status;

    // request codes
    localparam t_req REQ_RUN_A = 2'd0;
    localparam t_req REQ_RUN_B = 2'd1;
    localparam t_req REQ_FLUSH = 2'd2;

    // status codes
    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_BUSY = 2'd1;   // run for occupied side dropped
    localparam t_status ST_SAT  = 2'd2;   // held length clipped

    typedef struct packed {
        t_req        req_type;
        logic [15:0] run_value;
        logic [15:0] run_length;
    } t_item;

    typedef struct packed {
        logic        out_valid;
        logic [31:0] out_value;
        logic [31:0] out_length;
        logic        need_a;
        logic        need_b;
        t_status     status;
    } t_result;

endpackage

// ===== rtl/core/rsp_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsp_in_if
// Input channel: one run or flush request per word.
// ----------------------------------------------------------------------------
interface rsp_in_if import rsp_pkg::*; ();
    logic        valid;
    logic        ready;
    t_req        req_type;
    logic [15:0] run_value;
    logic [15:0] run_length;

    modport source (output valid, output req_type, output run_value,
                    output run_length, input ready);
    modport sink   (input valid, input req_type, input run_value,
                    input run_length, output ready);
endinterface

// ===== rtl/core/rsp_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsp_out_if
// Output channel: one result word per accepted input word.
// ----------------------------------------------------------------------------
interface rsp_out_if import rsp_pkg::*; ();
    logic        valid;
    logic        ready;
    logic        out_valid;
    logic [31:0] out_value;
    logic [31:0] out_length;
    logic        need_a;
    logic        need_b;
    t_status     status;

    modport source (output valid, output out_valid, output out_value,
                    output out_length, output need_a, output need_b,
                    output status, input ready);
    modport sink   (input valid, input out_valid, input out_value,
                    input out_length, input need_a, input need_b,
                    input status, output ready);
endinterface

// ===== rtl/core/rle_stream_product_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_stream_product_merge
// Element-wise product of two run-length encoded streams, merged on the fly.
// ----------------------------------------------------------------------------
// Each input word is a run for side A, a run for side B, or a flush; every
// accepted word yields exactly one result word, in order. Throughput is one
// word per clock while the sink is ready: a word is captured in the input
// register, is combined with the pending/held run state by one 16x16
// multiply plus a 32-bit compare and add, and lands in the output register.
// The input register refills while the output register still holds a
// result that the sink has not yet taken; the pipeline stalls only when
// both registers are occupied and the sink is not ready. A result carries
// need_a/need_b so the producer knows which side to feed next. A run sent
// to a side that is already occupied is dropped with status ST_BUSY; a
// zero-length run is silently discarded. When merging would overflow the
// 32-bit held length it clips at all ones and reports ST_SAT. A flush emits
// the held run (if any) and leaves pending side runs in place.
// ----------------------------------------------------------------------------
module rle_stream_product_merge import rsp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rsp_in_if.sink     i_in,
    rsp_out_if.source  o_out
);

    // input register
    logic    r_in_valid;
    t_item   r_in;
    // output register
    logic    r_out_valid;
    t_result r_res;

    logic    adv;        // word in the input register moves to the output
    t_result comb_res;

    assign adv        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in.req_type   <= i_in.req_type;
            r_in.run_value  <= i_in.run_value;
            r_in.run_length <= i_in.run_length;
        end
    end

    // state update happens exactly once per word, when it advances
    rsp_combine u_combine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (adv),
        .i_item   (r_in),
        .o_result (comb_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= comb_res;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.out_valid  = r_res.out_valid;
    assign o_out.out_value  = r_res.out_value;
    assign o_out.out_length = r_res.out_length;
    assign o_out.need_a     = r_res.need_a;
    assign o_out.need_b     = r_res.need_b;
    assign o_out.status     = r_res.status;

`ifndef SYNTHESIS
    // a combine always empties at least one side
    a_one_side_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_res.need_a || r_res.need_b))
        else $error("both sides still pending after a step");

    // no emitted run unless out_valid
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_res.out_valid) |->
            (r_res.out_value == 32'd0 && r_res.out_length == 32'd0))
        else $error("payload nonzero without out_valid");

    // dropped runs and saturating merges never emit
    a_err_no_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_res.status == ST_BUSY || r_res.status == ST_SAT))
            |-> !r_res.out_valid)
        else $error("emit together with error status");

    // a stalled input word is held, not lost
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !adv) |=> (r_in_valid && $stable(r_in)))
        else $error("input register changed while stalled");
`endif

endmodule

// ===== rtl/core/rsp_combine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsp_combine
// Pending-run and held-run state with the single-step combine/merge logic.
// ----------------------------------------------------------------------------
module rsp_combine import rsp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    output t_result o_result
);

    logic [15:0] r_a_value, r_a_left, r_b_value, r_b_left;
    logic        r_a_full, r_b_full;
    logic [31:0] r_held_value, r_held_length;
    logic        r_held_full;

    logic [15:0] n_a_value, n_a_left, n_b_value, n_b_left;
    logic        n_a_full, n_b_full;
    logic [31:0] n_held_value, n_held_length;
    logic        n_held_full;

    logic        is_run, sel_a, occupied, load;
    logic        a_full1, b_full1;
    logic [15:0] a_val1, b_val1, a_left1, b_left1, take, a_rem, b_rem;
    logic [31:0] prod;
    logic [32:0] sum;
    logic        combine, merge;

    always_comb begin
        is_run   = (i_item.req_type == REQ_RUN_A) || (i_item.req_type == REQ_RUN_B);
        sel_a    = (i_item.req_type == REQ_RUN_A);
        occupied = is_run && (sel_a ? r_a_full : r_b_full);
        load     = is_run && !occupied && (i_item.run_length != 16'd0);

        // side state after taking in the new run
        a_full1 = r_a_full  || (load && sel_a);
        b_full1 = r_b_full  || (load && !sel_a);
        a_val1  = (load && sel_a)  ? i_item.run_value  : r_a_value;
        a_left1 = (load && sel_a)  ? i_item.run_length : r_a_left;
        b_val1  = (load && !sel_a) ? i_item.run_value  : r_b_value;
        b_left1 = (load && !sel_a) ? i_item.run_length : r_b_left;

        combine = is_run && !occupied && a_full1 && b_full1;
        prod    = {16'd0, a_val1} * {16'd0, b_val1};
        take    = (a_left1 < b_left1) ? a_left1 : b_left1;
        a_rem   = a_left1 - take;
        b_rem   = b_left1 - take;
        merge   = r_held_full && (r_held_value == prod);
        sum     = {1'b0, r_held_length} + {17'd0, take};

        n_a_value     = a_val1;
        n_a_left      = a_left1;
        n_a_full      = a_full1;
        n_b_value     = b_val1;
        n_b_left      = b_left1;
        n_b_full      = b_full1;
        n_held_value  = r_held_value;
        n_held_length = r_held_length;
        n_held_full   = r_held_full;

        o_result            = '0;
        o_result.status     = occupied ? ST_BUSY : ST_OK;

        if (combine) begin
            if (merge) begin
                n_held_length = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                if (sum[32]) begin
                    o_result.status = ST_SAT;
                end
            end else begin
                if (r_held_full) begin
                    o_result.out_valid  = 1'b1;
                    o_result.out_value  = r_held_value;
                    o_result.out_length = r_held_length;
                end
                n_held_value  = prod;
                n_held_length = {16'd0, take};
                n_held_full   = 1'b1;
            end
            n_a_left = a_rem;
            n_b_left = b_rem;
            if (a_rem == 16'd0) begin
                n_a_full  = 1'b0;
                n_a_value = '0;
            end
            if (b_rem == 16'd0) begin
                n_b_full  = 1'b0;
                n_b_value = '0;
            end
        end else if ((i_item.req_type == REQ_FLUSH) && r_held_full) begin
            o_result.out_valid  = 1'b1;
            o_result.out_value  = r_held_value;
            o_result.out_length = r_held_length;
            n_held_full   = 1'b0;
            n_held_value  = '0;
            n_held_length = '0;
        end

        o_result.need_a = !n_a_full;
        o_result.need_b = !n_b_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_value     <= '0;
            r_a_left      <= '0;
            r_a_full      <= 1'b0;
            r_b_value     <= '0;
            r_b_left      <= '0;
            r_b_full      <= 1'b0;
            r_held_value  <= '0;
            r_held_length <= '0;
            r_held_full   <= 1'b0;
        end else if (i_step) begin
            r_a_value     <= n_a_value;
            r_a_left      <= n_a_left;
            r_a_full      <= n_a_full;
            r_b_value     <= n_b_value;
            r_b_left      <= n_b_left;
            r_b_full      <= n_b_full;
            r_held_value  <= n_held_value;
            r_held_length <= n_held_length;
            r_held_full   <= n_held_full;
        end
    end

endmodule
